>>> src/sfa_pkg.sv
// shared constants, operation codes and pipeline tag type for the fixed-point alu
package sfa_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SCALE_LOG2 = 16;  // scale is a power of two: 65536
  localparam int unsigned NUM_W     = DATA_W + SCALE_LOG2;  // widest dividend is |a| * scale
  localparam int unsigned DIV_STEPS = NUM_W;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_NEG = 4'd5;
  localparam logic [3:0] OP_ABS = 4'd6;
  localparam logic [3:0] OP_INV = 4'd7;
  localparam logic [3:0] OP_CMP = 4'd8;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // scale * scale, the inverse dividend
  localparam logic [NUM_W-1:0] INV_NUM = NUM_W'(64'd1 << (2 * SCALE_LOG2));

  typedef struct packed {
    logic [3:0]        op;
    logic              neg;
    logic              zdiv;
    logic [1:0]        order;
    logic [DATA_W-1:0] res;
  } sfa_tag_t;

endpackage

>>> src/sfa_divider.sv
// restoring unsigned divider, one quotient bit per pipeline stage
module sfa_divider import sfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DATA_W-1:0] den_i,
  input  sfa_tag_t          tag_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [DATA_W-1:0] rem_o,
  output sfa_tag_t          tag_o
);

  logic              valid_q [DIV_STEPS];
  logic [NUM_W-1:0]  nq_q    [DIV_STEPS];
  logic [DATA_W-1:0] rem_q   [DIV_STEPS];
  logic [DATA_W-1:0] den_q   [DIV_STEPS];
  sfa_tag_t          tag_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic              v_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] den_in;
    sfa_tag_t          tag_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic [NUM_W-1:0]  nq_d;
    logic [DATA_W-1:0] rem_d;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = valid_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    always_comb begin
      trial = {rem_in, nq_in[NUM_W-1]};
      diff  = trial - {1'b0, den_in};
      fits  = (trial >= {1'b0, den_in});
      nq_d  = {nq_in[NUM_W-2:0], fits};
      rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      nq_q[k]  <= nq_d;
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = valid_q[DIV_STEPS-1];
  assign quo_o   = nq_q[DIV_STEPS-1];
  assign rem_o   = rem_q[DIV_STEPS-1];
  assign tag_o   = tag_q[DIV_STEPS-1];

endmodule

>>> src/scaled_fixed_point_alu_top.sv
// top level of the pipelined scaled fixed-point alu
//
//  channel   | ports                                       | handshake
//  ----------+---------------------------------------------+--------------------
//  request   | req_type_i, operand_a_i, operand_b_i        | start_i, busy_o
//  result    | result_value_o, zero_divisor_o, order_o     | result_valid_o
//
// one item enters per cycle; every item passes from start to strobe through
// an input register, a decode and multiply stage, 48 stages of the divider
// (one quotient bit each) and an output register. all operations pass through
// the same stages so results leave in order. busy_o stays low since nothing stalls.
// reset clears only the valid bits along the pipeline.
module scaled_fixed_point_alu_top import sfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [3:0]        req_type_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  output logic              result_valid_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic              zero_divisor_o,
  output logic [1:0]        order_o
);

  assign busy_o = 1'b0;

  // stage 1: input register
  logic                     s1_valid_q;
  logic [3:0]               s1_op_q;
  logic signed [DATA_W-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= req_type_i;
    s1_a_q  <= operand_a_i;
    s1_b_q  <= operand_b_i;
  end

  // stage 2: decode, simple ops, multiply, divider operands
  logic [DATA_W-1:0] abs_a, abs_b;
  logic [NUM_W-1:0]  num_d;
  logic [DATA_W-1:0] den_d;
  sfa_tag_t          tag_d;

  always_comb begin
    abs_a = s1_a_q[DATA_W-1] ? (~s1_a_q + 1'b1) : s1_a_q;
    abs_b = s1_b_q[DATA_W-1] ? (~s1_b_q + 1'b1) : s1_b_q;
    tag_d       = '0;
    tag_d.op    = s1_op_q;
    num_d       = '0;
    den_d       = '0;
    case (s1_op_q)
      OP_ADD: tag_d.res = s1_a_q + s1_b_q;
      OP_SUB: tag_d.res = s1_a_q - s1_b_q;
      OP_NEG: tag_d.res = ~s1_a_q + 1'b1;
      OP_ABS: tag_d.res = abs_a;
      OP_DIV: begin
        num_d      = NUM_W'(abs_a) << SCALE_LOG2;
        den_d      = abs_b;
        tag_d.neg  = s1_a_q[DATA_W-1] ^ s1_b_q[DATA_W-1];
        tag_d.zdiv = (s1_b_q == '0);
      end
      OP_MOD: begin
        num_d      = NUM_W'(abs_a);
        den_d      = abs_b;
        tag_d.neg  = s1_a_q[DATA_W-1];
        tag_d.zdiv = (s1_b_q == '0);
      end
      OP_INV: begin
        num_d      = INV_NUM;
        den_d      = abs_a;
        tag_d.neg  = s1_a_q[DATA_W-1];
        tag_d.zdiv = (s1_a_q == '0);
      end
      OP_CMP: begin
        if (s1_a_q < s1_b_q) begin
          tag_d.order = ORD_LESS;
        end else if (s1_a_q == s1_b_q) begin
          tag_d.order = ORD_EQUAL;
        end else begin
          tag_d.order = ORD_GREATER;
        end
      end
      default: ;
    endcase
  end

  logic                       s2_valid_q;
  logic signed [2*DATA_W-1:0] s2_prod_q;
  logic [NUM_W-1:0]           s2_num_q;
  logic [DATA_W-1:0]          s2_den_q;
  sfa_tag_t                   s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_prod_q <= s1_a_q * s1_b_q;
    s2_num_q  <= num_d;
    s2_den_q  <= den_d;
    s2_tag_q  <= tag_d;
  end

  // product divided by scale, truncating toward zero, folded into the tag
  logic signed [2*DATA_W-1:0] prod_adj;
  sfa_tag_t                   div_tag;

  always_comb begin
    prod_adj = s2_prod_q + (s2_prod_q[2*DATA_W-1] ?
               (2*DATA_W)'((64'd1 << SCALE_LOG2) - 64'd1) : '0);
    div_tag  = s2_tag_q;
    if (s2_tag_q.op == OP_MUL) begin
      div_tag.res = DATA_W'(prod_adj >>> SCALE_LOG2);
    end
  end

  logic              dv_valid;
  logic [NUM_W-1:0]  dv_quo;
  logic [DATA_W-1:0] dv_rem;
  sfa_tag_t          dv_tag;

  sfa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .num_i   (s2_num_q),
    .den_i   (s2_den_q),
    .tag_i   (div_tag),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .tag_o   (dv_tag)
  );

  // output stage: sign fix of quotient or remainder
  logic [NUM_W-1:0]  quo_s;
  logic [DATA_W-1:0] rem_s;
  logic [DATA_W-1:0] res_d;

  always_comb begin
    quo_s = dv_tag.neg ? (~dv_quo + 1'b1) : dv_quo;
    rem_s = dv_tag.neg ? (~dv_rem + 1'b1) : dv_rem;
    case (dv_tag.op)
      OP_DIV, OP_INV: res_d = dv_tag.zdiv ? '0 : quo_s[DATA_W-1:0];
      OP_MOD:         res_d = dv_tag.zdiv ? '0 : rem_s;
      default:        res_d = dv_tag.res;
    endcase
  end

  logic              out_valid_q;
  logic [DATA_W-1:0] out_res_q;
  logic              out_zdiv_q;
  logic [1:0]        out_ord_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= res_d;
    out_zdiv_q <= dv_tag.zdiv;
    out_ord_q  <= dv_tag.order;
  end

  assign result_valid_o = out_valid_q;
  assign result_value_o = out_res_q;
  assign zero_divisor_o = out_zdiv_q;
  assign order_o        = out_ord_q;

  a_zdiv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_divisor_o |-> result_value_o == '0)
    else $error("zero divisor with nonzero result");

  a_zdiv_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && zero_divisor_o |-> order_o == ORD_LESS)
    else $error("zero divisor with compare outcome");

  a_order_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> order_o != 2'd3)
    else $error("bad compare outcome");

endmodule

>>> sim/scaled_fixed_point_alu_top_tb.sv
// testbench for the scaled fixed-point alu: directed table plus random items checked in order
module scaled_fixed_point_alu_top_tb;
  import sfa_pkg::*;

  localparam int  HALF_PERIOD = 4;
  localparam int  LATENCY     = 51;
  localparam int  NUM_RANDOM  = 1300;
  localparam int  CYCLE_LIMIT = 500000;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VAL = 32'sh7fff_ffff;
  localparam longint SCALE_VAL = 64'd1 << SCALE_LOG2;

  typedef struct {
    logic signed [31:0] value;
    logic               zdiv;
    logic [1:0]         order;
  } alu_result_t;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 typed;
    alu_result_t        res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [3:0]        req_type_i = OP_ADD;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic              busy_o;
  logic              result_valid_o;
  logic signed [31:0] result_value_o;
  logic              zero_divisor_o;
  logic [1:0]        order_o;

  alu_result_t pending_results[$];
  int          errors = 0;
  int          cycles = 0;

  scaled_fixed_point_alu_top uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .operand_a_i, .operand_b_i,
    .result_valid_o, .result_value_o, .zero_divisor_o, .order_o
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic alu_result_t alu_compute(logic [3:0] op, logic signed [31:0] a_in,
                                              logic signed [31:0] b_in);
    alu_result_t r;
    longint a, b, q;
    a = a_in;
    b = b_in;
    r.value = '0;
    r.zdiv = 1'b0;
    r.order = ORD_LESS;
    case (op)
      OP_ADD: r.value = 32'(a + b);
      OP_SUB: r.value = 32'(a - b);
      OP_MUL: begin
        q = (a * b) / SCALE_VAL;
        r.value = 32'(q);
      end
      OP_DIV: begin
        if (b == 0) r.zdiv = 1'b1;
        else r.value = 32'((a * SCALE_VAL) / b);
      end
      OP_MOD: begin
        if (b == 0) r.zdiv = 1'b1;
        else r.value = 32'(a % b);
      end
      OP_NEG: r.value = 32'(-a);
      OP_ABS: r.value = 32'(a < 0 ? -a : a);
      OP_INV: begin
        if (a == 0) r.zdiv = 1'b1;
        else r.value = 32'((SCALE_VAL * SCALE_VAL) / a);
      end
      OP_CMP: r.order = (a < b) ? ORD_LESS : ((a == b) ? ORD_EQUAL : ORD_GREATER);
      default: ;
    endcase
    return r;
  endfunction

  // results are accepted at the edge ending their strobe cycle
  always @(posedge clk_i) begin
    alu_result_t want;
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h zdiv=%b order=%0d", $time,
                 result_value_o, zero_divisor_o, order_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value, result_value_o);
          errors++;
        end
        if (zero_divisor_o !== want.zdiv) begin
          $display("%0t: zero_divisor expected %b actual %b", $time, want.zdiv, zero_divisor_o);
          errors++;
        end
        if (order_o !== want.order) begin
          $display("%0t: order expected %0d actual %0d", $time, want.order, order_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // holds start high until the item is taken, then drops it unless another follows
  task automatic send_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b,
                           alu_result_t want, bit more);
    start_i <= 1'b1;
    req_type_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(want);
    if (!more) start_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_VAL;
      1: return MAX_VAL;
      2: return '0;
      3: return 32'($urandom_range(0, 2)) - 1;
      4: return 32'sd65536 * ($urandom_range(0, 1) ? 1 : -1);
      5, 6: return 32'(int'($urandom_range(0, 20'hfffff)) - 20'h80000);
      default: return $urandom;
    endcase
  endfunction

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [3:0] op, logic signed [31:0] a,
                                    logic signed [31:0] b, bit typed,
                                    logic signed [31:0] v, logic z, logic [1:0] o);
    stim_row_t s;
    s.op = op; s.a = a; s.b = b; s.typed = typed;
    s.res.value = v; s.res.zdiv = z; s.res.order = o;
    return s;
  endfunction

  initial begin
    int burst;
    int gap;
    int n;
    logic [3:0] op;
    logic signed [31:0] a, b;
    directed = '{
      row(OP_ADD, MAX_VAL, 32'sd1, 1, MIN_VAL, 0, ORD_LESS),
      row(OP_SUB, MIN_VAL, 32'sd1, 1, MAX_VAL, 0, ORD_LESS),
      row(OP_MUL, MAX_VAL, MAX_VAL, 0, 0, 0, 0),
      row(OP_MUL, MIN_VAL, MIN_VAL, 0, 0, 0, 0),
      row(OP_MUL, -32'sd65536, 32'sd131072, 0, 0, 0, 0),
      row(OP_DIV, 32'sd12345, 32'sd0, 1, 0, 1, ORD_LESS),
      row(OP_DIV, MIN_VAL, -32'sd1, 0, 0, 0, 0),
      row(OP_DIV, -32'sd7, 32'sd3, 0, 0, 0, 0),
      row(OP_MOD, MIN_VAL, 32'sd0, 1, 0, 1, ORD_LESS),
      row(OP_MOD, MIN_VAL, -32'sd1, 1, 0, 0, ORD_LESS),
      row(OP_MOD, -32'sd7, 32'sd3, 1, -32'sd1, 0, ORD_LESS),
      row(OP_NEG, MIN_VAL, MAX_VAL, 1, MIN_VAL, 0, ORD_LESS),
      row(OP_NEG, MAX_VAL, 32'sd0, 1, -MAX_VAL, 0, ORD_LESS),
      row(OP_ABS, MIN_VAL, 32'sd5, 1, MIN_VAL, 0, ORD_LESS),
      row(OP_ABS, -32'sd1, MIN_VAL, 1, 32'sd1, 0, ORD_LESS),
      row(OP_INV, 32'sd0, 32'sd9, 1, 0, 1, ORD_LESS),
      row(OP_INV, 32'sd1, 32'sd0, 0, 0, 0, 0),
      row(OP_INV, MIN_VAL, 32'sd0, 0, 0, 0, 0),
      row(OP_INV, -32'sd3, 32'sd0, 0, 0, 0, 0),
      row(OP_CMP, MIN_VAL, MAX_VAL, 1, 0, 0, ORD_LESS),
      row(OP_CMP, MAX_VAL, MAX_VAL, 1, 0, 0, ORD_EQUAL),
      row(OP_CMP, MAX_VAL, MIN_VAL, 1, 0, 0, ORD_GREATER),
      row(4'd9, MAX_VAL, MAX_VAL, 1, 0, 0, ORD_LESS),
      row(4'd15, MIN_VAL, -32'sd1, 1, 0, 0, ORD_LESS)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].a, directed[i].b,
                directed[i].typed ? directed[i].res
                                  : alu_compute(directed[i].op, directed[i].a, directed[i].b),
                i != directed.size() - 1);
    end

    // wait for the pipeline to drain once before the random traffic
    while (pending_results.size() != 0) @(posedge clk_i);

    n = 0;
    while (n < NUM_RANDOM) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      // a zero gap lets the next burst follow without dropping start
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++) begin
        op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        a = pick_operand();
        b = pick_operand();
        if (op == OP_CMP && $urandom_range(0, 3) == 0) b = a;
        send_item(op, a, b, alu_compute(op, a, b),
                  (k != burst - 1 || gap == 0) && n != NUM_RANDOM - 1);
        n++;
      end
      repeat (gap) @(posedge clk_i);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
